// File: sv/fbc_pkg.sv
// Shared types and codes for the frustum box culler.
// No dependencies; imported by frustum_box_cull and fbc_checker.
package fbc_pkg;

	localparam int PLANE_COUNT_DEF = 6;
	localparam int COORD_W = 32;
	localparam int SLOT_W = 3;
	localparam int AXES = 3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [2*COORD_W-1:0] prod_t;
	typedef logic signed [2*COORD_W:0] psum_t;
	typedef logic signed [2*COORD_W+1:0] dist_t;

	typedef enum logic [1:0] {
		VERDICT_OUTSIDE = 2'd0,
		VERDICT_INTERSECT = 2'd1,
		VERDICT_INSIDE = 2'd2
	} verdict_t;

endpackage

// File: sv/frustum_box_cull.sv
// Frustum culling of axis-aligned boxes against a table of Q16.16 planes.
// Depends on fbc_pkg; checked by fbc_checker (bound in its own file).
//
// Usage:
//   Input channel (in_valid / in_stall): one request per accepted edge. A load
//   request (operation = OP_LOAD) writes plane_nx/ny/nz/plane_d into slot
//   plane_slot at once and gives no result; a slot at or beyond PLANE_COUNT is
//   dropped. A test request (operation = OP_TEST) carries the box corners and
//   gives one verdict: outside, intersecting or inside.
//   Output channel (out_valid / out_stall): one verdict per test request, in
//   request order.
//   Pipeline: five register stages (stage 1 to 4 and the verdict register); a
//   verdict passes through them in order and may be held by an output stall.
//   Throughput: one request per cycle while in_stall is low. Each plane has its
//   own lane of six 32x32 multipliers (near and far corner per axis), so the
//   multipliers set the pipeline depth, not the rate.
//   Stall: each stage advances when it is empty or the next stage advances.
//   While the receiver stalls, the verdict register holds and requests keep
//   flowing into empty stages; in_stall rises only when the pipe is full.
//   Reset: clears the plane table to zero (an unloaded plane decides nothing)
//   and all stage valid bits.
module frustum_box_cull #(
	parameter int PLANE_COUNT = fbc_pkg::PLANE_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic operation,
	input  logic [fbc_pkg::SLOT_W-1:0] plane_slot,
	input  logic signed [fbc_pkg::COORD_W-1:0] plane_nx,
	input  logic signed [fbc_pkg::COORD_W-1:0] plane_ny,
	input  logic signed [fbc_pkg::COORD_W-1:0] plane_nz,
	input  logic signed [fbc_pkg::COORD_W-1:0] plane_d,
	input  logic signed [fbc_pkg::COORD_W-1:0] min_x,
	input  logic signed [fbc_pkg::COORD_W-1:0] min_y,
	input  logic signed [fbc_pkg::COORD_W-1:0] min_z,
	input  logic signed [fbc_pkg::COORD_W-1:0] max_x,
	input  logic signed [fbc_pkg::COORD_W-1:0] max_y,
	input  logic signed [fbc_pkg::COORD_W-1:0] max_z,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] verdict
);
	import fbc_pkg::*;

	// Plane table, one entry per slot; each entry is read only by its own lane.
	coord_t nrm_q [PLANE_COUNT][AXES];
	coord_t ofs_q [PLANE_COUNT];

	// Stage ready chain: a stage takes new data when empty or draining.
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;
	logic v_s1, v_s2, v_s3, v_s4;
	logic out_valid_q;
	verdict_t verdict_q;

	logic in_acc;
	coord_t box_lo [AXES];
	coord_t box_hi [AXES];
	coord_t sorted_lo [AXES];
	coord_t sorted_hi [AXES];
	coord_t plane_n [AXES];

	// Stage 1: sorted box corners and a snapshot of the plane table.
	coord_t lo_s1 [AXES];
	coord_t hi_s1 [AXES];
	coord_t nrm_s1 [PLANE_COUNT][AXES];
	coord_t ofs_s1 [PLANE_COUNT];

	// Stage 2: products at the near (smallest) and far (largest) corner.
	prod_t near_s2 [PLANE_COUNT][AXES];
	prod_t far_s2 [PLANE_COUNT][AXES];
	coord_t ofs_s2 [PLANE_COUNT];

	// Stage 3: two partial sums per distance.
	psum_t near_a_s3 [PLANE_COUNT];
	psum_t near_b_s3 [PLANE_COUNT];
	psum_t far_a_s3 [PLANE_COUNT];
	psum_t far_b_s3 [PLANE_COUNT];

	// Stage 4: sign of the smallest and largest corner distance per plane.
	logic [PLANE_COUNT-1:0] near_neg_s4;
	logic [PLANE_COUNT-1:0] far_neg_s4;

	verdict_t verdict_d;

	assign rdy_out = !out_valid_q || !out_stall;
	assign rdy_s4 = !v_s4 || rdy_out;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign in_stall = !rdy_s1;
	assign in_acc = in_valid && rdy_s1;

	assign out_valid = out_valid_q;
	assign verdict = verdict_q;

	assign box_lo[0] = min_x;
	assign box_lo[1] = min_y;
	assign box_lo[2] = min_z;
	assign box_hi[0] = max_x;
	assign box_hi[1] = max_y;
	assign box_hi[2] = max_z;
	assign plane_n[0] = plane_nx;
	assign plane_n[1] = plane_ny;
	assign plane_n[2] = plane_nz;

	// Order each axis so the corner set is the same whichever field is larger.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			if (box_lo[a] <= box_hi[a]) begin
				sorted_lo[a] = box_lo[a];
				sorted_hi[a] = box_hi[a];
			end else begin
				sorted_lo[a] = box_hi[a];
				sorted_hi[a] = box_lo[a];
			end
		end
	end

	// Plane table: a load writes its slot on acceptance; out-of-range slots
	// match no entry and drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PLANE_COUNT; k++) begin
				for (int a = 0; a < AXES; a++) begin
					nrm_q[k][a] <= '0;
				end
				ofs_q[k] <= '0;
			end
		end else if (in_acc && operation == OP_LOAD) begin
			for (int k = 0; k < PLANE_COUNT; k++) begin
				if (plane_slot == SLOT_W'(k)) begin
					for (int a = 0; a < AXES; a++) begin
						nrm_q[k][a] <= plane_n[a];
					end
					ofs_q[k] <= plane_d;
				end
			end
		end
	end

	// Valid bits: only test requests enter the pipe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid && operation == OP_TEST;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_out) begin
				out_valid_q <= v_s4;
			end
		end
	end

	// Stage 1: capture the box and the table as it stands at acceptance, so
	// later loads do not touch tests already in flight.
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid && operation == OP_TEST) begin
			for (int a = 0; a < AXES; a++) begin
				lo_s1[a] <= sorted_lo[a];
				hi_s1[a] <= sorted_hi[a];
			end
			for (int k = 0; k < PLANE_COUNT; k++) begin
				for (int a = 0; a < AXES; a++) begin
					nrm_s1[k][a] <= nrm_q[k][a];
				end
				ofs_s1[k] <= ofs_q[k];
			end
		end
	end

	// Stage 2: a non-negative normal takes its smallest product at the low
	// coordinate, a negative one at the high coordinate.
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			for (int k = 0; k < PLANE_COUNT; k++) begin
				for (int a = 0; a < AXES; a++) begin
					if (nrm_s1[k][a] >= 0) begin
						near_s2[k][a] <= prod_t'(nrm_s1[k][a]) * prod_t'(lo_s1[a]);
						far_s2[k][a] <= prod_t'(nrm_s1[k][a]) * prod_t'(hi_s1[a]);
					end else begin
						near_s2[k][a] <= prod_t'(nrm_s1[k][a]) * prod_t'(hi_s1[a]);
						far_s2[k][a] <= prod_t'(nrm_s1[k][a]) * prod_t'(lo_s1[a]);
					end
				end
				ofs_s2[k] <= ofs_s1[k];
			end
		end
	end

	// Stage 3: x + y, and z + offset scaled from Q16.16 to Q32.32.
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			for (int k = 0; k < PLANE_COUNT; k++) begin
				near_a_s3[k] <= psum_t'(near_s2[k][0]) + psum_t'(near_s2[k][1]);
				near_b_s3[k] <= psum_t'(near_s2[k][2]) + (psum_t'(ofs_s2[k]) <<< 16);
				far_a_s3[k] <= psum_t'(far_s2[k][0]) + psum_t'(far_s2[k][1]);
				far_b_s3[k] <= psum_t'(far_s2[k][2]) + (psum_t'(ofs_s2[k]) <<< 16);
			end
		end
	end

	// Stage 4: keep only the signs of the exact distances.
	always_ff @(posedge clk) begin
		dist_t near_sum;
		dist_t far_sum;
		if (rdy_s4 && v_s3) begin
			for (int k = 0; k < PLANE_COUNT; k++) begin
				near_sum = dist_t'(near_a_s3[k]) + dist_t'(near_b_s3[k]);
				far_sum = dist_t'(far_a_s3[k]) + dist_t'(far_b_s3[k]);
				near_neg_s4[k] <= near_sum[$bits(dist_t)-1];
				far_neg_s4[k] <= far_sum[$bits(dist_t)-1];
			end
		end
	end

	// First deciding plane in slot order: far corner below means every corner
	// is below (outside); only the near corner below means both sides.
	always_comb begin
		logic decided;
		decided = 1'b0;
		verdict_d = VERDICT_INSIDE;
		for (int k = 0; k < PLANE_COUNT; k++) begin
			if (!decided && far_neg_s4[k]) begin
				verdict_d = VERDICT_OUTSIDE;
				decided = 1'b1;
			end else if (!decided && near_neg_s4[k]) begin
				verdict_d = VERDICT_INTERSECT;
				decided = 1'b1;
			end
		end
	end

	// Output register: hold while the receiver stalls.
	always_ff @(posedge clk) begin
		if (rdy_out && v_s4) begin
			verdict_q <= verdict_d;
		end
	end

endmodule

// File: sv/fbc_checker.sv
// Port-level checks for frustum_box_cull, attached by the bind below.
// Depends on fbc_pkg for the operation codes.
module fbc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic operation,
	input logic out_valid,
	input logic out_stall,
	input logic [1:0] verdict
);
	import fbc_pkg::*;

	// A held verdict stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(verdict))
		else $error("verdict changed while stalled");

	// With the output free the whole pipe drains, so requests are never stalled.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || !out_stall |-> !in_stall)
		else $error("input stalled while the output can drain");

	// Without output stalls from the accepting edge on, a test shows its verdict
	// after passing stages 1 to 4 and the output register; a load or an idle
	// cycle gives none.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=>
		out_valid == $past(in_valid && !in_stall && operation == OP_TEST, 5))
		else $error("result count or latency mismatch");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (.*);
